[rtl/bgc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_pkg
// shared types, register indexes and gesture codes for the button gesture
// classifier
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int NumButtonsDefault = 8;

  localparam int BtnW = 3;
  localparam int GestW = 3;
  localparam int TimeW = 32;
  localparam int MsW = 16;
  localparam int MaskW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  // gesture codes
  localparam logic [GestW-1:0] G_NONE = 3'd0;
  localparam logic [GestW-1:0] G_SHORT = 3'd1;
  localparam logic [GestW-1:0] G_LONG = 3'd2;
  localparam logic [GestW-1:0] G_REPEAT = 3'd3;
  localparam logic [GestW-1:0] G_DOUBLE = 3'd4;
  localparam logic [GestW-1:0] G_AP = 3'd5;
  localparam logic [GestW-1:0] G_RESET = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_WIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_BACK = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AP_HOLD = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RESET_HOLD = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_IMM_MASK = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_DWAIT_MASK = 3'd7;

  // register reset values
  localparam logic [MsW-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [MsW-1:0] LONG_PRESS_RST = 16'd600;
  localparam logic [MsW-1:0] DOUBLE_WIN_RST = 16'd350;
  localparam logic [MsW-1:0] REPEAT_BACK_RST = 16'd400;
  localparam logic [MsW-1:0] AP_HOLD_RST = 16'd5000;
  localparam logic [MsW-1:0] RESET_HOLD_RST = 16'd10000;
  localparam logic [MaskW-1:0] IMM_MASK_RST = 8'd0;
  localparam logic [MaskW-1:0] DWAIT_MASK_RST = 8'd2;

  typedef struct packed {
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
    logic [MsW-1:0] double_window_ms;
    logic [MsW-1:0] repeat_back_ms;
    logic [MsW-1:0] ap_hold_ms;
    logic [MsW-1:0] reset_hold_ms;
    logic [MaskW-1:0] immediate_mask;
    logic [MaskW-1:0] double_wait_mask;
  } bgc_cfg_t;

  // one per-button state entry as held in the state memory
  typedef struct packed {
    logic was_pressed;
    logic long_seen;
    logic double_pending;
    logic [TimeW-1:0] press_stamp;
    logic [TimeW-1:0] release_stamp;
  } bgc_entry_t;

endpackage : bgc_pkg
`default_nettype wire

[rtl/bgc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// configuration register file, written through a valid/ready port
// ----------------------------------------------------------------------------
module bgc_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bgc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bgc_pkg::CfgDataW-1:0] cfg_data,
  output bgc_pkg::bgc_cfg_t                 cfg
);
  import bgc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= DEBOUNCE_RST;
      cfg.long_press_ms <= LONG_PRESS_RST;
      cfg.double_window_ms <= DOUBLE_WIN_RST;
      cfg.repeat_back_ms <= REPEAT_BACK_RST;
      cfg.ap_hold_ms <= AP_HOLD_RST;
      cfg.reset_hold_ms <= RESET_HOLD_RST;
      cfg.immediate_mask <= IMM_MASK_RST;
      cfg.double_wait_mask <= DWAIT_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:    cfg.debounce_ms <= cfg_data;
        REG_LONG_PRESS:  cfg.long_press_ms <= cfg_data;
        REG_DOUBLE_WIN:  cfg.double_window_ms <= cfg_data;
        REG_REPEAT_BACK: cfg.repeat_back_ms <= cfg_data;
        REG_AP_HOLD:     cfg.ap_hold_ms <= cfg_data;
        REG_RESET_HOLD:  cfg.reset_hold_ms <= cfg_data;
        REG_IMM_MASK:    cfg.immediate_mask <= cfg_data[MaskW-1:0];
        REG_DWAIT_MASK:  cfg.double_wait_mask <= cfg_data[MaskW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule : bgc_cfg_regs
`default_nettype wire

[rtl/bgc_state_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_state_mem
// per-button state memory, registered read, valid bits for reset,
// forwarding of a write that lands on the edge of an overlapping read
// ----------------------------------------------------------------------------
module bgc_state_mem #(
  parameter int Depth = 8,
  parameter int AddrW = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rd_en,
  input  wire logic [AddrW-1:0]   rd_addr,
  output bgc_pkg::bgc_entry_t     rd_entry,
  input  wire logic               wr_en,
  input  wire logic [AddrW-1:0]   wr_addr,
  input  wire bgc_pkg::bgc_entry_t wr_entry
);
  import bgc_pkg::*;

  bgc_entry_t mem [Depth];
  logic [Depth-1:0] entry_valid;

  bgc_entry_t rd_data;
  logic rd_valid;
  logic fwd_hit;
  bgc_entry_t fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // read side holds its data while the consumer stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_valid <= entry_valid[rd_addr];
      fwd_hit <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_entry;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      rd_entry = fwd_data;
    end else if (rd_valid) begin
      rd_entry = rd_data;
    end else begin
      rd_entry = '0;
    end
  end

endmodule : bgc_state_mem
`default_nettype wire

[rtl/bgc_classify.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_classify
// gesture decision and next per-button state for one sample
// ----------------------------------------------------------------------------
module bgc_classify #(
  parameter int NumButtons = 8
) (
  input  wire bgc_pkg::bgc_cfg_t           cfg,
  input  wire bgc_pkg::bgc_entry_t         cur,
  input  wire logic [bgc_pkg::BtnW-1:0]    button_index,
  input  wire logic                        pressed,
  input  wire logic [bgc_pkg::TimeW-1:0]   now_ms,
  input  wire logic                        dim_cur,
  output bgc_pkg::bgc_entry_t              nxt,
  output logic                             wr,
  output logic [bgc_pkg::GestW-1:0]        gesture,
  output logic                             dim_next
);
  import bgc_pkg::*;

  logic in_range;
  logic immediate;
  logic dwait;
  logic is_zero;
  logic [TimeW-1:0] held_stamp;
  logic [TimeW-1:0] held_time;
  logic [TimeW-1:0] dur;
  logic [TimeW-1:0] since_release;

  always_comb begin
    in_range = 32'(button_index) < NumButtons;
    immediate = cfg.immediate_mask[button_index];
    dwait = cfg.double_wait_mask[button_index];
    is_zero = (button_index == '0);
    held_stamp = cur.was_pressed ? cur.press_stamp : now_ms;
    held_time = now_ms - held_stamp;
    dur = now_ms - cur.press_stamp;
    since_release = now_ms - cur.release_stamp;

    nxt = cur;
    gesture = G_NONE;
    dim_next = dim_cur;
    wr = in_range;

    if (in_range) begin
      if (pressed) begin
        nxt.was_pressed = 1'b1;
        if (immediate) begin
          if (!cur.was_pressed) begin
            gesture = G_SHORT;
          end
          nxt.press_stamp = now_ms;
        end else begin
          nxt.press_stamp = held_stamp;
          if (held_time > TimeW'(cfg.long_press_ms)) begin
            if (!cur.long_seen) begin
              dim_next = !dim_cur;
              gesture = G_LONG;
            end else if (!is_zero) begin
              gesture = G_REPEAT;
              nxt.press_stamp = now_ms - TimeW'(cfg.repeat_back_ms);
            end
            nxt.long_seen = 1'b1;
          end
        end
      end else if (cur.was_pressed) begin
        if (immediate) begin
          if (dur > TimeW'(cfg.debounce_ms)) begin
            nxt.was_pressed = 1'b0;
          end
        end else if (dur < TimeW'(cfg.debounce_ms)) begin
          // bounce: pending double left alone
          nxt.was_pressed = 1'b0;
        end else begin
          nxt.double_pending = 1'b0;
          if (is_zero && dur > TimeW'(cfg.ap_hold_ms)) begin
            gesture = (dur > TimeW'(cfg.reset_hold_ms)) ? G_RESET : G_AP;
          end else if (!cur.long_seen) begin
            if (!dwait) begin
              gesture = G_SHORT;
            end else if (cur.double_pending) begin
              gesture = G_DOUBLE;
            end else begin
              nxt.double_pending = 1'b1;
              nxt.release_stamp = now_ms;
            end
          end
          nxt.was_pressed = 1'b0;
          nxt.long_seen = 1'b0;
        end
      end else if (cur.double_pending &&
                   since_release > TimeW'(cfg.double_window_ms)) begin
        // double window ran out while released
        nxt.double_pending = 1'b0;
        gesture = G_SHORT;
      end
    end
  end

endmodule : bgc_classify
`default_nettype wire

[rtl/button_gesture_classifier_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_gesture_classifier_unit
// classifies poll samples of momentary buttons into short, long, repeat,
// double, access point hold and factory reset gestures
// ----------------------------------------------------------------------------
// a result passes stage 1 and the output register before it is offered
// throughput: one sample per cycle unless the event channel stalls, also
//   when consecutive samples hit one button (memory forwards prior write)
// reset: synchronous; clears the pipeline, dim direction and the per-entry
//   valid bits of the state memory (no clearing pass), restores config
// ----------------------------------------------------------------------------
module button_gesture_classifier_unit #(
  parameter int NUM_BUTTONS = bgc_pkg::NumButtonsDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // sample channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [bgc_pkg::BtnW-1:0]     button_index,
  input  wire logic                         pressed,
  input  wire logic [bgc_pkg::TimeW-1:0]    now_ms,
  // event channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [bgc_pkg::BtnW-1:0]          event_button,
  output logic [bgc_pkg::GestW-1:0]         gesture,
  output logic                              dim_up,
  // configuration write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bgc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bgc_pkg::CfgDataW-1:0] cfg_data
);
  import bgc_pkg::*;

  // only indexes below both the button count and the index range hold state
  localparam int Depth = (NUM_BUTTONS < (1 << BtnW)) ? NUM_BUTTONS : (1 << BtnW);
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  bgc_cfg_t cfg;

  // stage 1: sample whose state is being read out of memory
  logic s1_valid;
  logic [BtnW-1:0] s1_button;
  logic s1_pressed;
  logic [TimeW-1:0] s1_now;
  logic s1_go;

  logic accept;
  logic in_range;
  logic dim_dir;
  logic dim_next;

  bgc_entry_t cur_entry;
  bgc_entry_t nxt_entry;
  logic cls_wr;
  logic [GestW-1:0] cls_gesture;

  // stage 1 moves on whenever the output register is free or being drained
  assign s1_go = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign accept = in_valid && !in_stall;
  assign in_range = 32'(button_index) < NUM_BUTTONS;

  bgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // read on accept, write back as stage 1 retires
  bgc_state_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && in_range),
    .rd_addr  (button_index[AddrW-1:0]),
    .rd_entry (cur_entry),
    .wr_en    (s1_go && cls_wr),
    .wr_addr  (s1_button[AddrW-1:0]),
    .wr_entry (nxt_entry)
  );

  bgc_classify #(
    .NumButtons (NUM_BUTTONS)
  ) u_cls (
    .cfg          (cfg),
    .cur          (cur_entry),
    .button_index (s1_button),
    .pressed      (s1_pressed),
    .now_ms       (s1_now),
    .dim_cur      (dim_dir),
    .nxt          (nxt_entry),
    .wr           (cls_wr),
    .gesture      (cls_gesture),
    .dim_next     (dim_next)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_go);
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_button <= button_index;
      s1_pressed <= pressed;
      s1_now <= now_ms;
    end
  end

  // global dim direction, flips on every first long press
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_dir <= 1'b0;
    end else if (s1_go) begin
      dim_dir <= dim_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      event_button <= s1_button;
      gesture <= cls_gesture;
      dim_up <= dim_next;
    end
  end

endmodule : button_gesture_classifier_unit
`default_nettype wire
